### hw/rtl/fca_pkg.sv
// Shared types and constants of the file allocation table chain allocator.
// Used by fca_ctrl, fca_dp and the top level fat_chain_allocator.
// Depends on nothing.
package fca_pkg;

    // Link values and the largest index range that allocation searches.
    localparam logic [15:0] LINK_END   = 16'hFFFF;
    localparam int          INDEX_SPAN = 8192;

    // Action codes of an input item.
    localparam logic [2:0] ACT_LOAD   = 3'd0;
    localparam logic [2:0] ACT_NEW    = 3'd1;
    localparam logic [2:0] ACT_EXTEND = 3'd2;
    localparam logic [2:0] ACT_FREE   = 3'd3;
    localparam logic [2:0] ACT_WALK   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_CHAIN = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef enum logic {
        WA_CUR,
        WA_FOUND
    } t_wr_addr_sel;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_VAL,
        WD_END,
        WD_FOUND
    } t_wr_data_sel;

    // Where the old value of a written entry is known from.
    typedef enum logic [1:0] {
        OLD_RDDATA,
        OLD_ZERO,
        OLD_NONZERO
    } t_old_sel;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_CUR,
        RES_FOUND
    } t_res_sel;

    typedef struct packed {
        logic         load_in;
        logic         clr_step;
        logic         rd_cur;
        logic         scan_step;
        logic         wr_en;
        t_wr_addr_sel wr_addr_sel;
        t_wr_data_sel wr_data_sel;
        t_old_sel     old_sel;
        logic         advance;
        logic         emit;
        t_res_sel     res_sel;
        logic [1:0]   status;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic v_zero;
        logic v_end;
        logic v_range;
        logic cnt_last;
        logic cnt_zero;
        logic walk_done;
        logic scan_hit;
        logic scan_miss;
        logic out_free;
    } t_dp_stat;

endpackage

### hw/rtl/fca_dp.sv
// Datapath of the chain allocator: the table memory, link and scan registers,
// the used-entry counter and the result register.
// Depends on fca_pkg; driven by fca_ctrl through fca_pkg::t_dp_cmd.
module fca_dp #(
    parameter int TABLE_ENTRIES = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fca_pkg::t_dp_cmd   i_cmd,
    output fca_pkg::t_dp_stat  o_stat,
    input  logic [12:0]        i_block_index,
    input  logic [12:0]        i_step_count,
    input  logic [15:0]        i_entry_value,
    input  logic [13:0]        i_block_count,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [12:0]        o_result_index,
    output logic [1:0]         o_status,
    output logic [13:0]        o_used_count
);

    localparam int          AW       = $clog2(TABLE_ENTRIES);
    localparam int          UW       = $clog2(TABLE_ENTRIES + 1);
    localparam logic [16:0] TE17     = 17'(TABLE_ENTRIES);
    localparam logic [16:0] TE_LAST  = 17'(TABLE_ENTRIES - 1);
    localparam logic [16:0] WIN_MAX  = (TABLE_ENTRIES < fca_pkg::INDEX_SPAN) ?
                                       17'(TABLE_ENTRIES) : 17'(fca_pkg::INDEX_SPAN);

    logic [15:0]   r_table [TABLE_ENTRIES];
    logic [15:0]   r_rd_data;
    logic [AW-1:0] r_cur;
    logic [AW-1:0] r_found;
    logic [16:0]   r_cnt;
    logic [13:0]   r_scan_ptr;
    logic          r_pend;
    logic [12:0]   r_steps;
    logic [15:0]   r_val;
    logic [UW-1:0] r_used;
    logic          r_out_valid;
    logic [12:0]   r_out_index;
    logic [1:0]    r_out_status;
    logic [13:0]   r_out_used;

    logic [16:0]   w_blk17;
    logic [16:0]   w_bc17;
    logic [16:0]   w_lim17;
    logic [16:0]   w_ptr17;
    logic [16:0]   w_ptr_m1;
    logic [16:0]   w_v17;
    logic [16:0]   w_cur17;
    logic [16:0]   w_found17;
    logic [16:0]   w_used17;
    logic          w_ptr_ok;
    logic          w_hit;
    logic          w_scan_issue;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [15:0]   w_wr_data;
    logic          w_old_nz;
    logic          w_new_nz;
    logic          w_out_free;
    logic [12:0]   w_res_index;

    assign w_blk17   = {4'b0, i_block_index};
    assign w_bc17    = {3'b0, i_block_count};
    assign w_lim17   = (w_bc17 < WIN_MAX) ? w_bc17 : WIN_MAX;
    assign w_ptr17   = {3'b0, r_scan_ptr};
    assign w_ptr_m1  = w_ptr17 - 17'd1;
    assign w_v17     = {1'b0, r_rd_data};
    assign w_cur17   = 17'(r_cur);
    assign w_found17 = 17'(r_found);
    assign w_used17  = 17'(r_used);

    // The scan keeps one read in flight; a hit refers to the entry just below the pointer.
    assign w_ptr_ok     = w_ptr17 < w_lim17;
    assign w_hit        = r_pend && (r_rd_data == 16'd0);
    assign w_scan_issue = i_cmd.scan_step && !w_hit && w_ptr_ok;

    assign w_rd_en   = i_cmd.rd_cur || w_scan_issue;
    assign w_rd_addr = w_scan_issue ? w_ptr17[AW-1:0] : r_cur;

    assign w_wr_en = i_cmd.wr_en || i_cmd.clr_step;

    always_comb begin
        if (i_cmd.clr_step) begin
            w_wr_addr = r_cnt[AW-1:0];
        end else if (i_cmd.wr_addr_sel == fca_pkg::WA_FOUND) begin
            w_wr_addr = r_found;
        end else begin
            w_wr_addr = r_cur;
        end
    end

    always_comb begin
        if (i_cmd.clr_step) begin
            w_wr_data = 16'd0;
        end else begin
            unique case (i_cmd.wr_data_sel)
                fca_pkg::WD_ZERO:  w_wr_data = 16'd0;
                fca_pkg::WD_VAL:   w_wr_data = r_val;
                fca_pkg::WD_END:   w_wr_data = fca_pkg::LINK_END;
                fca_pkg::WD_FOUND: w_wr_data = w_found17[15:0];
            endcase
        end
    end

    always_comb begin
        case (i_cmd.old_sel)
            fca_pkg::OLD_RDDATA:  w_old_nz = (r_rd_data != 16'd0);
            fca_pkg::OLD_NONZERO: w_old_nz = 1'b1;
            default:              w_old_nz = 1'b0;
        endcase
    end

    assign w_new_nz = (w_wr_data != 16'd0);

    always_comb begin
        case (i_cmd.res_sel)
            fca_pkg::RES_CUR:   w_res_index = w_cur17[12:0];
            fca_pkg::RES_FOUND: w_res_index = w_found17[12:0];
            default:            w_res_index = 13'd0;
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // Table memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_table[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_table[w_rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cur   <= w_blk17[AW-1:0];
            r_steps <= i_step_count;
            r_val   <= i_entry_value;
        end else if (i_cmd.advance) begin
            r_cur <= w_v17[AW-1:0];
        end
        if (i_cmd.load_in) begin
            r_scan_ptr <= 14'd0;
        end else if (w_scan_issue) begin
            r_scan_ptr <= r_scan_ptr + 14'd1;
        end
        if (i_cmd.scan_step && w_hit) begin
            r_found <= w_ptr_m1[AW-1:0];
        end
        if (i_cmd.emit) begin
            r_out_index  <= w_res_index;
            r_out_status <= i_cmd.status;
            r_out_used   <= w_used17[13:0];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 17'd0;
            r_pend      <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_cnt  <= 17'd0;
                r_pend <= 1'b0;
            end else begin
                if (i_cmd.advance || i_cmd.clr_step) begin
                    r_cnt <= r_cnt + 17'd1;
                end
                if (w_scan_issue) begin
                    r_pend <= 1'b1;
                end
            end
            if (i_cmd.wr_en) begin
                if (!w_old_nz && w_new_nz) begin
                    r_used <= r_used + UW'(1);
                end else if (w_old_nz && !w_new_nz) begin
                    r_used <= r_used - UW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.in_range  = w_blk17 < TE17;
    assign o_stat.v_zero    = (r_rd_data == 16'd0);
    assign o_stat.v_end     = (r_rd_data == fca_pkg::LINK_END);
    assign o_stat.v_range   = (w_v17 >= TE17);
    assign o_stat.cnt_last  = (r_cnt == TE_LAST);
    assign o_stat.cnt_zero  = (r_cnt == 17'd0);
    assign o_stat.walk_done = (r_cnt == {4'b0, r_steps});
    assign o_stat.scan_hit  = w_hit;
    assign o_stat.scan_miss = !w_hit && !w_ptr_ok;
    assign o_stat.out_free  = w_out_free;

    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_out_index;
    assign o_status       = r_out_status;
    assign o_used_count   = r_out_used;

    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_rd_en && w_wr_en))
        else $error("table read and write in the same cycle");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(TABLE_ENTRIES))
        else $error("used-entry count above table size");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("result written over an item not yet taken");

endmodule

### hw/rtl/fca_ctrl.sv
// Controller state machine of the chain allocator: sequences table reads,
// writes and scans for one action and hands the result to the datapath.
// Depends on fca_pkg; drives fca_dp through fca_pkg::t_dp_cmd.
module fca_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_action,
    input  fca_pkg::t_dp_stat  i_stat,
    output fca_pkg::t_dp_cmd   o_cmd
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_READ    = 4'd2;
    localparam logic [3:0] S_EV_LOAD = 4'd3;
    localparam logic [3:0] S_EV_TAIL = 4'd4;
    localparam logic [3:0] S_SCAN    = 4'd5;
    localparam logic [3:0] S_WR_LINK = 4'd6;
    localparam logic [3:0] S_WR_END  = 4'd7;
    localparam logic [3:0] S_EV_FREE = 4'd8;
    localparam logic [3:0] S_EV_WALK = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [2:0]        r_action;
    logic [2:0]        n_action;
    logic [1:0]        r_status;
    logic [1:0]        n_status;
    fca_pkg::t_res_sel r_res_sel;
    fca_pkg::t_res_sel n_res_sel;
    logic              w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_status  = r_status;
        n_res_sel = r_res_sel;

        o_cmd             = '0;
        o_cmd.wr_addr_sel = fca_pkg::WA_CUR;
        o_cmd.wr_data_sel = fca_pkg::WD_ZERO;
        o_cmd.old_sel     = fca_pkg::OLD_RDDATA;
        o_cmd.res_sel     = fca_pkg::RES_ZERO;
        o_cmd.status      = fca_pkg::ST_OK;

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_action      = i_action;
                    n_status      = fca_pkg::ST_OK;
                    n_res_sel     = fca_pkg::RES_ZERO;
                    // Unused codes do nothing; a new chain ignores the index.
                    priority if (i_action > fca_pkg::ACT_WALK) begin
                        n_state = S_DONE;
                    end else if (i_action != fca_pkg::ACT_NEW && !i_stat.in_range) begin
                        n_status = fca_pkg::ST_RANGE;
                        n_state  = S_DONE;
                    end else if (i_action == fca_pkg::ACT_NEW) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_cur = 1'b1;
                case (r_action)
                    fca_pkg::ACT_LOAD:   n_state = S_EV_LOAD;
                    fca_pkg::ACT_EXTEND: n_state = S_EV_TAIL;
                    fca_pkg::ACT_FREE:   n_state = S_EV_FREE;
                    default:             n_state = S_EV_WALK;
                endcase
            end
            S_EV_LOAD: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_data_sel = fca_pkg::WD_VAL;
                n_state           = S_DONE;
            end
            S_EV_TAIL: begin
                if (!i_stat.v_end) begin
                    n_status = fca_pkg::ST_CHAIN;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_hit) begin
                    n_state = (r_action == fca_pkg::ACT_NEW) ? S_WR_END : S_WR_LINK;
                end else if (i_stat.scan_miss) begin
                    n_status = fca_pkg::ST_FULL;
                    n_state  = S_DONE;
                end
            end
            S_WR_LINK: begin
                // The tail held the end mark, so its old value is nonzero.
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_data_sel = fca_pkg::WD_FOUND;
                o_cmd.old_sel     = fca_pkg::OLD_NONZERO;
                n_state           = S_WR_END;
            end
            S_WR_END: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_addr_sel = fca_pkg::WA_FOUND;
                o_cmd.wr_data_sel = fca_pkg::WD_END;
                o_cmd.old_sel     = fca_pkg::OLD_ZERO;
                n_res_sel         = fca_pkg::RES_FOUND;
                n_state           = S_DONE;
            end
            S_EV_FREE: begin
                if (i_stat.v_zero) begin
                    n_status = fca_pkg::ST_CHAIN;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.wr_en = 1'b1;
                    if (i_stat.v_end) begin
                        n_state = S_DONE;
                    end else if (i_stat.v_range) begin
                        n_status = fca_pkg::ST_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = i_stat.cnt_last ? S_DONE : S_READ;
                    end
                end
            end
            S_EV_WALK: begin
                if (i_stat.walk_done) begin
                    // With no steps to take, only the start itself is checked.
                    if (i_stat.cnt_zero && i_stat.v_zero) begin
                        n_status = fca_pkg::ST_CHAIN;
                    end else begin
                        n_res_sel = fca_pkg::RES_CUR;
                    end
                    n_state = S_DONE;
                end else if (i_stat.v_zero || i_stat.v_end) begin
                    n_status = fca_pkg::ST_CHAIN;
                    n_state  = S_DONE;
                end else if (i_stat.v_range) begin
                    n_status = fca_pkg::ST_RANGE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = r_res_sel;
                    o_cmd.status  = r_status;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_action  <= fca_pkg::ACT_LOAD;
            r_status  <= fca_pkg::ST_OK;
            r_res_sel <= fca_pkg::RES_ZERO;
        end else begin
            r_state   <= n_state;
            r_action  <= n_action;
            r_status  <= n_status;
            r_res_sel <= n_res_sel;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("controller stayed idle after taking an item");

endmodule

### hw/rtl/fat_chain_allocator.sv
// File allocation table chain allocator, top level.
// Usage: one command item in on the s_axis channel, one result item out on
// the m_axis channel for every command. The cfg channel writes the data
// block count that bounds the free-entry search; write it only while idle.
// After reset the table is cleared one entry per cycle, with s_axis_tready
// low; cfg writes are taken throughout.
// Unused actions and indexes out of range go straight to the result. New chain
// and extend scan from index 0 up to the first free entry, or through the whole
// search window when none is free; extend first checks that the index is a
// tail. Load writes one entry; free and walk read the chain one entry at a time.
// The table memory takes one access per cycle, read or write, and one item is
// worked on at a time.
// The result sits in an output register; the next command is accepted while
// it waits. A stalled receiver holds the finished result and stops the
// following command only when that one is done.
// Depends on fca_pkg, fca_ctrl and fca_dp.
module fat_chain_allocator #(
    parameter int TABLE_ENTRIES = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action [2:0], block_index [15:3], step_count [28:16], entry_value [44:29]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_index [12:0], status [14:13], used_count [28:15]
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [13:0] i_cfg_data
);

    logic [13:0]       r_block_count;
    fca_pkg::t_dp_cmd  w_cmd;
    fca_pkg::t_dp_stat w_stat;
    logic [12:0]       w_result_index;
    logic [1:0]        w_status;
    logic [13:0]       w_used_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= 14'd8192;
        end else if (i_cfg_valid) begin
            r_block_count <= i_cfg_data;
        end
    end

    fca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_action   (s_axis_tdata[2:0]),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fca_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_block_index  (s_axis_tdata[15:3]),
        .i_step_count   (s_axis_tdata[28:16]),
        .i_entry_value  (s_axis_tdata[44:29]),
        .i_block_count  (r_block_count),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_result_index (w_result_index),
        .o_status       (w_status),
        .o_used_count   (w_used_count)
    );

    assign m_axis_tdata = {3'b000, w_used_count, w_status, w_result_index};

endmodule

### tb/sv/fat_chain_allocator_tb.sv
// Self-checking testbench for fat_chain_allocator: a directed command table, then
// random chain traffic over several allocation windows, checked by a predictor.
// Depends on fca_pkg and the fat_chain_allocator RTL.
module fat_chain_allocator_tb;

    localparam int TBL         = 8192;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int LOW_REGION  = 63;

    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    // Last field in the lowest bits.
    typedef struct packed {
        logic [15:0] val;
        logic [12:0] steps;
        logic [12:0] blk;
        logic [2:0]  act;
    } t_fat_cmd;

    typedef struct packed {
        logic [13:0] used;
        logic [1:0]  st;
        logic [12:0] idx;
    } t_fat_res;

    typedef struct packed {
        logic [2:0]  act;
        logic [12:0] blk;
        logic [12:0] steps;
        logic [15:0] val;
        logic        chk;
        logic [12:0] e_idx;
        logic [1:0]  e_st;
        logic [13:0] e_used;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [13:0] i_cfg_data = '0;

    // Predictor state.
    logic [15:0] fat_next [TBL];
    int          fat_used;
    int          alloc_window;

    t_fat_res    pending_results [$];
    int          chain_head [$];
    int          chain_tail [$];
    int          chain_len [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;

    t_row dir_rows [25] = '{
        '{fca_pkg::ACT_WALK, 13'd0, 13'd0, 16'h0000, 1'b1, 13'd0, fca_pkg::ST_CHAIN, 14'd0},
        '{fca_pkg::ACT_FREE, 13'd8191, 13'd0, 16'h0000, 1'b1, 13'd0, fca_pkg::ST_CHAIN, 14'd0},
        '{fca_pkg::ACT_NEW, 13'd0, 13'd0, 16'h0000, 1'b1, 13'd0, fca_pkg::ST_OK, 14'd1},
        '{fca_pkg::ACT_EXTEND, 13'd0, 13'd0, 16'h0000, 1'b0, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{fca_pkg::ACT_EXTEND, 13'd1, 13'd0, 16'h0000, 1'b0, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{fca_pkg::ACT_EXTEND, 13'd0, 13'd0, 16'h0000, 1'b1, 13'd0, fca_pkg::ST_CHAIN, 14'd3},
        '{fca_pkg::ACT_WALK, 13'd0, 13'd2, 16'h0000, 1'b0, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{fca_pkg::ACT_WALK, 13'd0, 13'd3, 16'h0000, 1'b1, 13'd0, fca_pkg::ST_CHAIN, 14'd3},
        '{fca_pkg::ACT_WALK, 13'd2, 13'd0, 16'h0000, 1'b0, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{fca_pkg::ACT_LOAD, 13'd8191, 13'd0, 16'hFFFF, 1'b0, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{fca_pkg::ACT_WALK, 13'd8191, 13'd8191, 16'h0000, 1'b1, 13'd0,
          fca_pkg::ST_CHAIN, 14'd4},
        '{fca_pkg::ACT_LOAD, 13'd8191, 13'd0, 16'h1FFF, 1'b0, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{fca_pkg::ACT_WALK, 13'd8191, 13'd8191, 16'h0000, 1'b1, 13'd8191,
          fca_pkg::ST_OK, 14'd4},
        '{fca_pkg::ACT_FREE, 13'd8191, 13'd0, 16'h0000, 1'b1, 13'd0, fca_pkg::ST_CHAIN, 14'd3},
        '{fca_pkg::ACT_LOAD, 13'd100, 13'd0, 16'h2000, 1'b0, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{fca_pkg::ACT_WALK, 13'd100, 13'd1, 16'h0000, 1'b1, 13'd0, fca_pkg::ST_RANGE, 14'd4},
        '{fca_pkg::ACT_FREE, 13'd100, 13'd0, 16'h0000, 1'b1, 13'd0, fca_pkg::ST_RANGE, 14'd3},
        '{fca_pkg::ACT_LOAD, 13'd3, 13'd0, 16'h0000, 1'b0, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{fca_pkg::ACT_LOAD, 13'd2, 13'd0, 16'h0000, 1'b0, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{fca_pkg::ACT_FREE, 13'd0, 13'd0, 16'h0000, 1'b1, 13'd0, fca_pkg::ST_CHAIN, 14'd0},
        '{ACT_SPARE_FIRST, 13'd8191, 13'd8191, 16'hFFFF, 1'b1, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{ACT_SPARE_FIRST + 3'd1, 13'd0, 13'd0, 16'h0000, 1'b1, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{ACT_SPARE_LAST, 13'd0, 13'd0, 16'h0000, 1'b1, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{fca_pkg::ACT_NEW, 13'd0, 13'd0, 16'h0000, 1'b0, 13'd0, fca_pkg::ST_OK, 14'd0},
        '{fca_pkg::ACT_FREE, 13'd0, 13'd0, 16'h0000, 1'b1, 13'd0, fca_pkg::ST_OK, 14'd0}
    };

    fat_chain_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic void set_link(input int at, input logic [15:0] v);
        if (fat_next[at] == 16'd0 && v != 16'd0) begin
            fat_used++;
        end else if (fat_next[at] != 16'd0 && v == 16'd0) begin
            fat_used--;
        end
        fat_next[at] = v;
    endfunction

    // Lowest free entry inside the allocation window, or -1.
    function automatic int first_free();
        int lim;
        int i;
        lim = alloc_window;
        if (lim > TBL) lim = TBL;
        if (lim > fca_pkg::INDEX_SPAN) lim = fca_pkg::INDEX_SPAN;
        for (i = 0; i < lim; i++) begin
            if (fat_next[i] == 16'd0) return i;
        end
        return -1;
    endfunction

    function automatic t_fat_res predict_fat(input t_fat_cmd c);
        t_fat_res    r;
        int          cur;
        int          f;
        int          n;
        logic [15:0] v;
        r = '0;
        cur = int'(c.blk);
        if (c.act <= fca_pkg::ACT_WALK && c.act != fca_pkg::ACT_NEW && cur >= TBL) begin
            r.st = fca_pkg::ST_RANGE;
        end else begin
            case (c.act)
                fca_pkg::ACT_LOAD: set_link(cur, c.val);
                fca_pkg::ACT_NEW: begin
                    f = first_free();
                    if (f < 0) begin
                        r.st = fca_pkg::ST_FULL;
                    end else begin
                        set_link(f, fca_pkg::LINK_END);
                        r.idx = f[12:0];
                    end
                end
                fca_pkg::ACT_EXTEND: begin
                    if (fat_next[cur] != fca_pkg::LINK_END) begin
                        r.st = fca_pkg::ST_CHAIN;
                    end else begin
                        f = first_free();
                        if (f < 0) begin
                            r.st = fca_pkg::ST_FULL;
                        end else begin
                            set_link(cur, f[15:0]);
                            set_link(f, fca_pkg::LINK_END);
                            r.idx = f[12:0];
                        end
                    end
                end
                fca_pkg::ACT_FREE: begin
                    // Entries cleared before a broken link stay cleared.
                    for (n = 0; n < TBL; n++) begin
                        v = fat_next[cur];
                        if (v == 16'd0) begin
                            r.st = fca_pkg::ST_CHAIN;
                            break;
                        end
                        set_link(cur, 16'd0);
                        if (v == fca_pkg::LINK_END) break;
                        if (v >= TBL) begin
                            r.st = fca_pkg::ST_RANGE;
                            break;
                        end
                        cur = int'(v);
                    end
                end
                fca_pkg::ACT_WALK: begin
                    if (fat_next[cur] == 16'd0) begin
                        r.st = fca_pkg::ST_CHAIN;
                    end else begin
                        for (n = 0; n < int'(c.steps); n++) begin
                            v = fat_next[cur];
                            if (v == 16'd0 || v == fca_pkg::LINK_END) begin
                                r.st = fca_pkg::ST_CHAIN;
                                break;
                            end
                            if (v >= TBL) begin
                                r.st = fca_pkg::ST_RANGE;
                                break;
                            end
                            cur = int'(v);
                        end
                        if (r.st == fca_pkg::ST_OK) r.idx = cur[12:0];
                    end
                end
                default: ;
            endcase
        end
        r.used = fat_used[13:0];
        return r;
    endfunction

    task automatic issue_cmd(input t_fat_cmd c, input bit use_typed, input t_fat_res typed,
                             output t_fat_res pred);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, c};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_fat(c);
        if (use_typed) begin
            pending_results.push_back(typed);
        end else begin
            pending_results.push_back(pred);
        end
    endtask

    task automatic run_cmd(input logic [2:0] act, input int blk, input int steps,
                           input int val, output t_fat_res pred);
        t_fat_cmd c;
        c.act = act;
        c.blk = blk[12:0];
        c.steps = steps[12:0];
        c.val = val[15:0];
        issue_cmd(c, 1'b0, '0, pred);
    endtask

    task automatic sender_gap();
        while (!no_idle && $urandom_range(99) < 29) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_window(input int w);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= w[13:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        alloc_window = int'(w[13:0]);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed chain traffic on tracked chains, plus loads and
    // operations on arbitrary indexes that break or loop chains.
    task automatic random_cmd();
        int       pick;
        int       k;
        int       steps;
        t_fat_res r;
        pick = $urandom_range(99);
        if (chain_head.size() >= 12 && pick < 18) pick = 60;
        if (chain_head.size() == 0 && pick >= 18 && pick < 66) pick = 0;
        if (pick < 18) begin
            run_cmd(fca_pkg::ACT_NEW, $urandom_range(8191), $urandom_range(8191),
                    $urandom_range(65535), r);
            if (r.st == fca_pkg::ST_OK) begin
                chain_head.push_back(int'(r.idx));
                chain_tail.push_back(int'(r.idx));
                chain_len.push_back(1);
            end
        end else if (pick < 40) begin
            k = $urandom_range(chain_head.size() - 1);
            run_cmd(fca_pkg::ACT_EXTEND, chain_tail[k], $urandom_range(8191),
                    $urandom_range(65535), r);
            if (r.st == fca_pkg::ST_OK) begin
                chain_tail[k] = int'(r.idx);
                chain_len[k] = chain_len[k] + 1;
            end
        end else if (pick < 54) begin
            k = $urandom_range(chain_head.size() - 1);
            if ($urandom_range(19) == 0) begin
                steps = $urandom_range(8191);
            end else begin
                steps = $urandom_range(chain_len[k] + 1);
            end
            run_cmd(fca_pkg::ACT_WALK, chain_head[k], steps, $urandom_range(65535), r);
        end else if (pick < 66) begin
            k = $urandom_range(chain_head.size() - 1);
            run_cmd(fca_pkg::ACT_FREE, chain_head[k], $urandom_range(8191),
                    $urandom_range(65535), r);
            chain_head.delete(k);
            chain_tail.delete(k);
            chain_len.delete(k);
        end else if (pick < 78) begin
            case ($urandom_range(3))
                0: run_cmd(fca_pkg::ACT_LOAD, $urandom_range(LOW_REGION), 0, 0, r);
                1: run_cmd(fca_pkg::ACT_LOAD, $urandom_range(LOW_REGION), 0,
                           fca_pkg::LINK_END, r);
                2: run_cmd(fca_pkg::ACT_LOAD, $urandom_range(LOW_REGION),
                           $urandom_range(8191), $urandom_range(LOW_REGION), r);
                default: run_cmd(fca_pkg::ACT_LOAD, $urandom_range(8191),
                                 $urandom_range(8191), $urandom_range(65535), r);
            endcase
        end else if (pick < 84) begin
            run_cmd(fca_pkg::ACT_EXTEND, $urandom_range(LOW_REGION), 0,
                    $urandom_range(65535), r);
        end else if (pick < 90) begin
            if ($urandom_range(1) == 0) begin
                run_cmd(fca_pkg::ACT_FREE, $urandom_range(LOW_REGION), 0, 0, r);
            end else begin
                run_cmd(fca_pkg::ACT_FREE, $urandom_range(8191), 0, 0, r);
            end
        end else if (pick < 96) begin
            run_cmd(fca_pkg::ACT_WALK, $urandom_range(8191), $urandom_range(8191),
                    $urandom_range(65535), r);
        end else begin
            run_cmd(3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST)),
                    $urandom_range(8191), $urandom_range(8191), $urandom_range(65535), r);
        end
    endtask

    // Result side: random stalls, one long hold-off on request.
    initial begin : result_sink
        int       hold_left;
        t_fat_res got;
        t_fat_res want;
        hold_left = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= 29);
            end
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_fat_res'(m_axis_tdata[28:0]);
                if (pending_results.size() == 0) begin
                    report_mismatch("result item with no command outstanding");
                end else begin
                    want = pending_results.pop_front();
                    if (got.idx != want.idx)
                        report_mismatch($sformatf("result_index %0d, wanted %0d",
                                                  got.idx, want.idx));
                    if (got.st != want.st)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  got.st, want.st));
                    if (got.used != want.used)
                        report_mismatch($sformatf("used_count %0d, wanted %0d",
                                                  got.used, want.used));
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : command_source
        int       windows [8] = '{16383, 40, 0, 300, 8192, 1, 5000, 2};
        int       ph;
        int       n;
        t_fat_cmd c;
        t_fat_res typed;
        t_fat_res r;
        foreach (fat_next[i]) fat_next[i] = 16'd0;
        fat_used = 0;
        alloc_window = TBL;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Written during the clearing pass, which the block allows.
        write_window(8192);
        for (n = 0; n < 25; n++) begin
            c.act = dir_rows[n].act;
            c.blk = dir_rows[n].blk;
            c.steps = dir_rows[n].steps;
            c.val = dir_rows[n].val;
            typed.idx = dir_rows[n].e_idx;
            typed.st = dir_rows[n].e_st;
            typed.used = dir_rows[n].e_used;
            sender_gap();
            issue_cmd(c, dir_rows[n].chk, typed, r);
        end
        drain_results();

        for (ph = 0; ph < 8; ph++) begin
            write_window(windows[ph]);
            no_idle = (ph == 4);
            // The sink stalls for a long stretch while commands keep coming.
            if (ph == 1) hold_req = 1'b1;
            for (n = 0; n < 91; n++) begin
                if (ph == 3 && n == 45) drain_results();
                sender_gap();
                random_cmd();
            end
            drain_results();
        end

        repeat (64) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
